FILE: rtl/core/nla_pkg.sv
// shared types, operation codes and register indexes of the lambda automaton acceptor
`timescale 1ns / 1ps
package nla_pkg;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int FIELD_W    = 4;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // operation codes of an input transaction
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_SYMBOL = 2'd2;
  localparam logic [OP_W-1:0] OP_END    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

  // input transaction payload
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FIELD_W-1:0] from_state;
    logic [FIELD_W-1:0] to_state;
    logic [FIELD_W-1:0] symbol;
    logic               is_lambda;
  } in_t;

  // result transaction payload
  typedef struct packed {
    logic accepted;
    logic dead;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the accepted item
    logic wrk_start;  // work set takes the start state, expansion marks cleared
    logic wrk_clr;    // work set cleared before a move
    logic move;       // one step of the symbol move scan
    logic cl_init;    // expansion marks cleared before a closure
    logic close;      // one step of the lambda closure scan
    logic act_load;   // active set takes the work set
    logic emit;       // result leaves, active set cleared
    logic add_rd;     // read the entry of an added transition
    logic add_wr;     // write it back with the new successor bit
    logic clr_step;   // clear one table entry
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic add_ok;     // added transition is in range
    logic cl_done;    // closure reached its fixed point
    logic ptr_last;   // scan pointer at the last state
    logic clr_last;   // clear sweep at the last entry
  } sts_t;

endpackage

FILE: rtl/core/nla_ctrl.sv
// controller state machine sequencing table updates, moves, closures and results
`timescale 1ns / 1ps
module nla_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_accept,
  input  logic [nla_pkg::OP_W-1:0] in_op,
  input  logic                     out_free,
  input  nla_pkg::sts_t            sts,
  output nla_pkg::cmd_t            cmd,
  output logic                     idle
);
  import nla_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ADD      = 4'd2;
  localparam logic [3:0] S_ADD_WR   = 4'd3;
  localparam logic [3:0] S_START_CL = 4'd4;
  localparam logic [3:0] S_MOVE     = 4'd5;
  localparam logic [3:0] S_MOVE_END = 4'd6;
  localparam logic [3:0] S_CLOSE    = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  logic [3:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic            fresh_r, fresh_nxt;

  // next state and command decode
  always_comb begin
    cmd       = '0;
    idle      = 1'b0;
    state_nxt = state_r;
    op_nxt    = op_r;
    fresh_nxt = fresh_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        idle = 1'b1;
        if (in_accept) begin
          cmd.load = 1'b1;
          op_nxt   = in_op;
          unique case (in_op) inside
            OP_ADD: begin
              state_nxt = S_ADD;
            end
            OP_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            OP_SYMBOL, OP_END: begin
              if (fresh_r) begin
                cmd.wrk_start = 1'b1;
                state_nxt     = S_START_CL;
              end else if (in_op == OP_SYMBOL) begin
                cmd.wrk_clr = 1'b1;
                state_nxt   = S_MOVE;
              end else begin
                state_nxt = S_EMIT;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        if (sts.add_ok) begin
          cmd.add_rd = 1'b1;
          state_nxt  = S_ADD_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_START_CL: begin
        // closure of the start state opens a new word
        if (sts.cl_done) begin
          cmd.act_load = 1'b1;
          fresh_nxt    = 1'b0;
          if (op_r == OP_SYMBOL) begin
            cmd.wrk_clr = 1'b1;
            state_nxt   = S_MOVE;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          cmd.close = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_MOVE_END;
        end
      end
      S_MOVE_END: begin
        cmd.cl_init = 1'b1;
        state_nxt   = S_CLOSE;
      end
      S_CLOSE: begin
        if (sts.cl_done) begin
          cmd.act_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.close = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          fresh_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r    <= OP_ADD;
      fresh_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      fresh_r <= fresh_nxt;
    end
  end

endmodule

FILE: rtl/core/nla_dp.sv
// datapath: successor table memory, state sets and scan pointer
`timescale 1ns / 1ps
module nla_dp #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nla_pkg::in_t                in_data,
  input  logic [nla_pkg::FIELD_W-1:0] start_state,
  input  logic [nla_pkg::MASK_W-1:0]  accept_mask,
  input  nla_pkg::cmd_t               cmd,
  output nla_pkg::sts_t               sts,
  output nla_pkg::out_t               res
);
  import nla_pkg::*;

  localparam int COLS   = NUM_SYMBOLS + 1;
  localparam int DEPTH  = NUM_STATES * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW     = $clog2(NUM_STATES);
  localparam int CW     = $clog2(COLS);

  localparam logic [CW-1:0]         LAMBDA_COL = CW'(NUM_SYMBOLS);
  localparam logic [NUM_STATES-1:0] ONE_SET    = NUM_STATES'(1);
  localparam logic [SW-1:0]         LAST_ST    = SW'(NUM_STATES - 1);
  localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(DEPTH - 1);

  // table entry of one state and one column, row-major by state
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [SW-1:0] st,
                                                   input logic [CW-1:0] col);
    return ADDR_W'(st) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  in_t                   item_r;
  logic [NUM_STATES-1:0] act_r, act_nxt;
  logic [NUM_STATES-1:0] wrk_r, wrk_nxt;
  logic [NUM_STATES-1:0] exp_r, exp_nxt;
  logic [SW-1:0]         ptr_r, ptr_nxt, ptr_inc;
  logic                  pend_r, pend_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;

  logic [NUM_STATES-1:0] tbl_mem [DEPTH];
  logic [NUM_STATES-1:0] rdata_r;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr, add_addr;
  logic [NUM_STATES-1:0] wr_data;

  logic                  from_ok, to_ok, sym_ok, start_ok;
  logic [SW-1:0]         from_idx, to_idx, start_idx;
  logic [CW-1:0]         sym_col, add_col;
  logic                  cand_move, cand_cl;
  logic [NUM_STATES-1:0] mask_n;

  // field decode of the held item
  assign from_ok   = 32'(item_r.from_state) < NUM_STATES;
  assign to_ok     = 32'(item_r.to_state) < NUM_STATES;
  assign sym_ok    = 32'(item_r.symbol) < NUM_SYMBOLS;
  assign start_ok  = 32'(start_state) < NUM_STATES;
  assign from_idx  = SW'(item_r.from_state);
  assign to_idx    = SW'(item_r.to_state);
  assign start_idx = SW'(start_state);
  assign sym_col   = CW'(item_r.symbol);
  assign add_col   = item_r.is_lambda ? LAMBDA_COL : sym_col;
  assign add_addr  = entry_addr(from_idx, add_col);

  // scan candidates: active states for a move, unexpanded states for a closure
  assign cand_move = act_r[ptr_r] & sym_ok;
  assign cand_cl   = wrk_r[ptr_r] & ~exp_r[ptr_r];
  assign ptr_inc   = (ptr_r == LAST_ST) ? '0 : ptr_r + 1'b1;

  // next-state logic of sets, pointer and memory ports
  always_comb begin
    act_nxt      = act_r;
    wrk_nxt      = wrk_r;
    exp_nxt      = exp_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = 1'b0;
    clr_addr_nxt = clr_addr_r;
    rd_en        = 1'b0;
    rd_addr      = add_addr;
    wr_en        = 1'b0;
    wr_addr      = clr_addr_r;
    wr_data      = '0;

    // successor row read last cycle joins the work set
    if (pend_r) begin
      wrk_nxt = wrk_r | rdata_r;
    end
    if (cmd.wrk_start) begin
      wrk_nxt = start_ok ? (ONE_SET << start_idx) : '0;
      exp_nxt = '0;
      ptr_nxt = '0;
    end
    if (cmd.wrk_clr) begin
      wrk_nxt = '0;
      ptr_nxt = '0;
    end
    if (cmd.cl_init) begin
      exp_nxt = '0;
      ptr_nxt = '0;
    end
    if (cmd.move) begin
      rd_addr  = entry_addr(ptr_r, sym_col);
      rd_en    = cand_move;
      pend_nxt = cand_move;
      ptr_nxt  = ptr_inc;
    end
    if (cmd.close) begin
      rd_addr  = entry_addr(ptr_r, LAMBDA_COL);
      rd_en    = cand_cl;
      pend_nxt = cand_cl;
      ptr_nxt  = ptr_inc;
      if (cand_cl) begin
        exp_nxt[ptr_r] = 1'b1;
      end
    end
    if (cmd.add_rd) begin
      rd_en = 1'b1;
    end
    if (cmd.add_wr) begin
      wr_en   = 1'b1;
      wr_addr = add_addr;
      wr_data = rdata_r | (ONE_SET << to_idx);
    end
    if (cmd.clr_step) begin
      wr_en        = 1'b1;
      clr_addr_nxt = (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + 1'b1;
    end
    if (cmd.act_load) begin
      act_nxt = wrk_r;
    end
    if (cmd.emit) begin
      act_nxt = '0;
    end
  end

  // control and set registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= '0;
      wrk_r      <= '0;
      exp_r      <= '0;
      ptr_r      <= '0;
      pend_r     <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      act_r      <= act_nxt;
      wrk_r      <= wrk_nxt;
      exp_r      <= exp_nxt;
      ptr_r      <= ptr_nxt;
      pend_r     <= pend_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // successor table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= tbl_mem[rd_addr];
    end
  end

  // status and result
  assign mask_n       = NUM_STATES'(accept_mask);
  assign sts.add_ok   = from_ok & to_ok & (item_r.is_lambda | sym_ok);
  assign sts.cl_done  = ~|(wrk_r & ~exp_r) & ~pend_r;
  assign sts.ptr_last = (ptr_r == LAST_ST);
  assign sts.clr_last = (clr_addr_r == LAST_ADDR);
  assign res.accepted = |(act_r & mask_n);
  assign res.dead     = ~|act_r;

endmodule

FILE: rtl/core/nfa_lambda_acceptor_core.sv
// top level of the lambda automaton acceptor: configuration, output register, assertions
//
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_stall    in_data  (operation, states, symbol, lambda)
//  out_      output     out_valid / out_stall  out_data (accepted, dead)
//  cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One transaction is worked at a time; in_stall is low only while the controller is idle.
//  Add: a read-modify-write of one table entry. Clear: a sweep that clears every table entry.
//  Symbol: a move scan over all states, then a closure of one scan over all states per round
//  of newly reached states (one table read per cycle); a word's first item adds a closure of
//  the start state. End of word: waits while a stalled result holds the output register.
//  After reset a clearing sweep of all NUM_STATES*(NUM_SYMBOLS+1) entries (272 by default) runs
//  with in_stall high; configuration writes are taken at all times.
//  A waiting result sits in the output register while the next transactions proceed.
`timescale 1ns / 1ps
module nfa_lambda_acceptor_core #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nla_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nla_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nla_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nla_pkg::*;

  logic [FIELD_W-1:0] start_state_r;
  logic [MASK_W-1:0]  accept_mask_r;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r;
  out_t               res;
  cmd_t               cmd;
  sts_t               sts;
  logic               idle, in_accept, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~idle;
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_STATE: start_state_r <= cfg_data[FIELD_W-1:0];
        CFG_ACCEPT_MASK: accept_mask_r <= cfg_data[MASK_W-1:0];
      endcase
    end
  end

  nla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_op     (in_data.operation),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle)
  );

  nla_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .start_state (start_state_r),
    .accept_mask (accept_mask_r),
    .cmd         (cmd),
    .sts         (sts),
    .res         (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result is only produced into a free output slot
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> out_free)
    else $error("result emitted while output register holds a stalled transaction");

  // the clearing sweep after reset keeps the input closed
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open during the clearing sweep after reset");

  // a new output transaction follows an emit command
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid rose without an emitted result");

  // an empty set cannot accept
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.accepted && out_data.dead))
    else $error("result both accepted and dead");

endmodule

FILE: tb/sv/nla_verdict_checker.sv
// checker for the lambda automaton acceptor: tracks the transition table, predicts verdicts, compares
`timescale 1ns / 1ps
module nla_verdict_checker #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  nla_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  nla_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [nla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nla_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import nla_pkg::*;

  localparam int LAMBDA_COL = NUM_SYMBOLS;
  localparam int PRINT_MAX  = 40;

  typedef logic [NUM_STATES-1:0] set_t;

  // mirror of the block state and its registers
  set_t               succ_tbl [NUM_STATES][NUM_SYMBOLS+1];
  set_t               active_set;
  logic               word_fresh;
  logic [FIELD_W-1:0] start_state;
  logic [MASK_W-1:0]  accept_mask;

  // verdicts of finished words, oldest first
  out_t verdict_q [$];

  out_t verdict;
  out_t want;
  set_t moved;
  set_t seed;
  int   row;
  int   col;

  task automatic report_mismatch(string what);
    if (fail_count < PRINT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    fail_count++;
  endtask

  // grow a state set along lambda moves until nothing new is reached
  function automatic set_t lambda_close(set_t start_set);
    set_t cur;
    set_t grown;
    int   round;
    int   s;
    bit   grew;
    cur   = start_set;
    round = 0;
    grew  = 1'b1;
    while (grew && round < NUM_STATES) begin
      grown = cur;
      for (s = 0; s < NUM_STATES; s++) begin
        if (cur[s]) grown |= succ_tbl[s][LAMBDA_COL];
      end
      grew = (grown != cur);
      cur  = grown;
      round++;
    end
    return cur;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (row = 0; row < NUM_STATES; row++) begin
        for (col = 0; col <= NUM_SYMBOLS; col++) succ_tbl[row][col] = '0;
      end
      active_set  = '0;
      word_fresh  = 1'b1;
      start_state = '0;
      accept_mask = '0;
      verdict_q.delete();
    end else begin
      // result transaction against the oldest verdict
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result with no word finished: accepted=%b dead=%b",
                                    out_data.accepted, out_data.dead));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.accepted !== want.accepted) begin
            report_mismatch($sformatf("accepted is %b, predicted %b",
                                      out_data.accepted, want.accepted));
          end
          if (out_data.dead !== want.dead) begin
            report_mismatch($sformatf("dead is %b, predicted %b", out_data.dead, want.dead));
          end
        end
      end

      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_STATE: start_state = cfg_data[FIELD_W-1:0];
          CFG_ACCEPT_MASK: accept_mask = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end

      // input transaction
      if (in_valid && !in_stall) begin
        // a word starts from the closure of the start state, taken on its first item
        if (word_fresh && (in_data.operation == OP_SYMBOL || in_data.operation == OP_END)) begin
          seed = '0;
          if (start_state < NUM_STATES) begin
            seed[start_state] = 1'b1;
          end
          active_set = lambda_close(seed);
          word_fresh = 1'b0;
        end
        case (in_data.operation)
          OP_ADD: begin
            if (in_data.from_state < NUM_STATES && in_data.to_state < NUM_STATES &&
                (in_data.is_lambda || in_data.symbol < NUM_SYMBOLS)) begin
              col = in_data.is_lambda ? LAMBDA_COL : int'(in_data.symbol);
              succ_tbl[in_data.from_state][col][in_data.to_state] = 1'b1;
            end
          end
          OP_CLEAR: begin
            for (row = 0; row < NUM_STATES; row++) begin
              for (col = 0; col <= NUM_SYMBOLS; col++) succ_tbl[row][col] = '0;
            end
          end
          OP_SYMBOL: begin
            moved = '0;
            if (in_data.symbol < NUM_SYMBOLS) begin
              for (row = 0; row < NUM_STATES; row++) begin
                if (active_set[row]) moved |= succ_tbl[row][in_data.symbol];
              end
            end
            active_set = lambda_close(moved);
          end
          OP_END: begin
            verdict.accepted = |(active_set & set_t'(accept_mask));
            verdict.dead     = (active_set == '0);
            verdict_q.push_back(verdict);
            active_set = '0;
            word_fresh = 1'b1;
          end
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// testbench top of the lambda automaton acceptor: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import nla_pkg::*;

  localparam int NUM_STATES   = 16;
  localparam int NUM_SYMBOLS  = 16;
  localparam int ITEM_TARGET  = 1500;
  localparam int CALM_TAIL    = 150;
  // covers the slowest item: a clearing sweep, or a symbol with start and move closures
  localparam int DRAIN_CYCLES = 640;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int WORDS_PER_SET = 20;
  localparam int IN_W         = $bits(in_t);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int verdicts_pending;
  int items_sent  = 0;
  int cycle_count = 0;
  int gap_pct     = 25;
  bit calm        = 1'b0;
  bit hold_done   = 1'b0;

  nfa_lambda_acceptor_core #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nla_verdict_checker #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) verdicts (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (mismatches),
    .pending    (verdicts_pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_t make_item(logic [OP_W-1:0] op, logic [FIELD_W-1:0] src,
                                    logic [FIELD_W-1:0] dst, logic [FIELD_W-1:0] sym,
                                    logic lam);
    in_t item;
    item.operation  = op;
    item.from_state = src;
    item.to_state   = dst;
    item.symbol     = sym;
    item.is_lambda  = lam;
    return item;
  endfunction

  // offer one input transaction, with an optional gap ahead of it
  task automatic push_item(in_t item);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every verdict, then let trailing table work finish
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // transition among the first span states over the first alpha symbols
  task automatic push_random_add(int span, int alpha);
    logic lam;
    logic [FIELD_W-1:0] sym;
    lam = ($urandom_range(0, 3) == 0);
    sym = lam ? FIELD_W'($urandom_range(0, 15)) : FIELD_W'($urandom_range(0, alpha - 1));
    push_item(make_item(OP_ADD, FIELD_W'($urandom_range(0, span - 1)),
                        FIELD_W'($urandom_range(0, span - 1)), sym, lam));
  endtask

  // fully random transaction, clears kept rare since each one sweeps the table
  task automatic push_noise();
    logic [IN_W-1:0] raw;
    in_t item;
    raw  = IN_W'($urandom());
    item = raw;
    if (item.operation == OP_CLEAR && $urandom_range(0, 3) != 0) item.operation = OP_ADD;
    push_item(item);
  endtask

  // one word, mostly over the working alphabet, with occasional table edits inside it
  task automatic push_word(int span, int alpha);
    int len;
    int i;
    int pick;
    logic [FIELD_W-1:0] sym;
    len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 79);
      if (pick < 2) push_random_add(span, alpha);
      else if (pick == 2) push_item(make_item(OP_CLEAR, '0, '0, '0, 1'b0));
      else if (pick == 3) push_noise();
      sym = ($urandom_range(0, 15) == 0) ? FIELD_W'($urandom_range(0, 15))
                                          : FIELD_W'($urandom_range(0, alpha - 1));
      push_item(make_item(OP_SYMBOL, FIELD_W'($urandom()), FIELD_W'($urandom()), sym,
                          1'($urandom())));
    end
    push_item(make_item(OP_END, FIELD_W'($urandom()), FIELD_W'($urandom()),
                        FIELD_W'($urandom()), 1'($urandom())));
  endtask

  // result side: random stall bursts, quiet stretches and one long hold
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && !hold_done && items_sent >= 300 && in_valid) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(20, 100)) @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int set_idx;
    int span;
    int alpha;
    int n_adds;
    int i;
    logic [FIELD_W-1:0] first;
    logic [MASK_W-1:0]  finals;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_START_STATE, '0);
    write_reg(CFG_ACCEPT_MASK, 16'h8001);

    // empty word on the empty table
    push_item(make_item(OP_END, '0, '0, '0, 1'b0));
    // lambda cycle between 0 and 1, symbol 15 into 15, lambda out of 15
    push_item(make_item(OP_ADD, 4'd0, 4'd1, 4'd0, 1'b1));
    push_item(make_item(OP_ADD, 4'd1, 4'd0, 4'd15, 1'b1));
    push_item(make_item(OP_ADD, 4'd1, 4'd15, 4'd15, 1'b0));
    push_item(make_item(OP_ADD, 4'd15, 4'd2, 4'd15, 1'b1));
    push_item(make_item(OP_SYMBOL, '0, '0, 4'd15, 1'b0));
    push_item(make_item(OP_END, '0, '0, '0, 1'b0));
    // symbol with no move: set dies
    push_item(make_item(OP_SYMBOL, '0, '0, 4'd0, 1'b0));
    push_item(make_item(OP_END, 4'd15, 4'd15, 4'd15, 1'b1));
    // clear in the middle of a word
    push_item(make_item(OP_SYMBOL, '0, '0, 4'd15, 1'b0));
    push_item(make_item(OP_CLEAR, 4'd15, 4'd15, 4'd15, 1'b1));
    push_item(make_item(OP_SYMBOL, '0, '0, 4'd15, 1'b0));
    push_item(make_item(OP_END, '0, '0, '0, 1'b0));
    // empty word after the clear
    push_item(make_item(OP_END, '0, '0, '0, 1'b0));
    // field extremes and a transition added mid-word
    push_item(make_item(OP_ADD, 4'd15, 4'd15, 4'd15, 1'b0));
    push_item(make_item(OP_ADD, 4'd0, 4'd0, 4'd0, 1'b0));
    push_item(make_item(OP_SYMBOL, '0, '0, 4'd0, 1'b0));
    push_item(make_item(OP_ADD, 4'd0, 4'd15, 4'd0, 1'b0));
    push_item(make_item(OP_SYMBOL, '0, '0, 4'd0, 1'b0));
    push_item(make_item(OP_END, '0, '0, '0, 1'b0));

    // random automata, each with a run of words
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      span  = (set_idx == 0) ? NUM_STATES : $urandom_range(2, NUM_STATES);
      alpha = $urandom_range(1, 4);
      if (set_idx == 0) begin
        first  = 4'd15;
        finals = '0;
      end else if (set_idx == 1) begin
        first  = '0;
        finals = '1;
      end else begin
        first  = ($urandom_range(0, 5) == 0) ? 4'd15 : FIELD_W'($urandom_range(0, span - 1));
        finals = MASK_W'($urandom());
      end
      write_reg(CFG_START_STATE, CFG_DATA_W'(first));
      write_reg(CFG_ACCEPT_MASK, CFG_DATA_W'(finals));
      gap_pct = (set_idx % 3) * 25;

      push_item(make_item(OP_CLEAR, FIELD_W'($urandom()), FIELD_W'($urandom()),
                          FIELD_W'($urandom()), 1'($urandom())));
      n_adds = $urandom_range(span, 3 * span);
      for (i = 0; i < n_adds; i++) push_random_add(span, alpha);

      for (i = 0; i < WORDS_PER_SET && items_sent < ITEM_TARGET; i++) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        push_word(span, alpha);
        calm = (items_sent >= ITEM_TARGET - CALM_TAIL);
      end
      set_idx++;
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
